FILE: rtl/sru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sru_pkg;
  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic [6:0]         distinct_count;
    logic               overflow;
  } out_item_t;
endpackage
`default_nettype wire

FILE: rtl/sort_and_remove_duplicates_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                          | direction
// in      | in_valid, in_stall, in_data    | requests into the block
// out     | out_valid, out_stall, out_data | sorted distinct values out
// a load walks the store from the top down, a read and a compare step per
// shifted element; a request on a full store is dropped without a walk
// the last request then walks the store one element per cycle while out_stall
// lets the result register drain, after a priming read, and a flush step
// sends the held value
// reset is synchronous, active low; it clears the count and control state only
// out_stall holds the result register and the emission walk
module sort_and_remove_duplicates_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sru_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sru_pkg::out_item_t  out_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_EMIT_RD, S_EMIT, S_FLUSH
  } state_t;

  state_t state_r;
  logic [31:0] mem [sru_pkg::MaxItems];
  logic [sru_pkg::CntW-1:0] cnt_r;     // loaded elements
  logic [sru_pkg::CntW-1:0] pos_r;     // insertion hole / emit index
  logic [sru_pkg::CntW-1:0] dist_r;    // distinct values emitted
  logic signed [31:0] v_r, rd_r, prev_r;
  logic last_r, ovf_r, have_prev_r;
  logic emit_room, emit_go;

  // result register is free or drains this cycle
  assign emit_room = !out_valid || !out_stall;

  // a new distinct value pushes out the held one; the flush sends the final one
  assign emit_go = emit_room &&
                   ((state_r == S_EMIT && have_prev_r && rd_r != prev_r) ||
                    state_r == S_FLUSH);

  logic [sru_pkg::IdxW-1:0] rd_addr;
  assign rd_addr = (state_r == S_IDLE || state_r == S_EMIT_RD ||
                    (state_r == S_EMIT && emit_room)) ? pos_r[sru_pkg::IdxW-1:0]
                 : pos_r[sru_pkg::IdxW-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      have_prev_r <= 1'b0;
      pos_r <= '0;
      dist_r <= '0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v_r <= in_data.value;
            last_r <= in_data.last;
            if (cnt_r < sru_pkg::CntW'(sru_pkg::MaxItems)) begin
              pos_r <= cnt_r;
              state_r <= S_RD;
            end else begin
              ovf_r <= 1'b1;
              pos_r <= '0;
              state_r <= in_data.last ? S_EMIT_RD : S_IDLE;
              have_prev_r <= 1'b0;
              dist_r <= '0;
            end
          end
        end
        S_RD: begin
          // fetch the element below the hole
          if (pos_r == '0) begin
            mem[0] <= v_r;
            cnt_r <= cnt_r + 1'b1;
            pos_r <= '0;
            have_prev_r <= 1'b0;
            dist_r <= '0;
            state_r <= last_r ? S_EMIT_RD : S_IDLE;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (v_r < rd_r) begin
            mem[pos_r[sru_pkg::IdxW-1:0]] <= rd_r;
            pos_r <= pos_r - 1'b1;
            state_r <= S_RD;
          end else begin
            mem[pos_r[sru_pkg::IdxW-1:0]] <= v_r;
            cnt_r <= cnt_r + 1'b1;
            pos_r <= '0;
            have_prev_r <= 1'b0;
            dist_r <= '0;
            state_r <= last_r ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: begin
          // prime the read of mem[0]
          pos_r <= pos_r + 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // rd_r holds mem[pos_r - 1], prev_r the last distinct value not yet sent
          if (emit_room) begin
            if (emit_go) begin
              out_data.value_res <= prev_r;
              out_data.overflow <= ovf_r;
              out_data.last_res <= 1'b0;
              out_data.distinct_count <= 7'd0;
              dist_r <= dist_r + 1'b1;
            end
            prev_r <= rd_r;
            have_prev_r <= 1'b1;
            if (pos_r == cnt_r) begin
              state_r <= S_FLUSH;
            end else begin
              pos_r <= pos_r + 1'b1;
              state_r <= S_EMIT;
            end
          end
        end
        S_FLUSH: begin
          // the held value is the largest one
          if (emit_room) begin
            out_data.value_res <= prev_r;
            out_data.overflow <= ovf_r;
            out_data.last_res <= 1'b1;
            out_data.distinct_count <= 7'(dist_r + 1'b1);
            cnt_r <= '0;
            ovf_r <= 1'b0;
            pos_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
